// ===== src/esc_pkg.sv =====
// ============================================================================
// esc_pkg
// Shared types, constants and register codes of the sensor compensation core.
// ============================================================================
package esc_pkg;

    typedef logic [31:0] t_w32;
    typedef logic [63:0] t_w64;
    typedef logic [19:0] t_adc20;
    typedef logic [15:0] t_adc16;

    typedef enum logic [2:0] {
        REG_TEMP_COEFFS  = 3'd0,
        REG_PRESS_LOW    = 3'd1,
        REG_PRESS_HIGH   = 3'd2,
        REG_PRESS_NINE   = 3'd3,
        REG_HUMID_COEFFS = 3'd4
    } t_cfg_idx;

    // pipeline indexes of results, counted from the input register
    localparam int LAT_TFINE  = 3;
    localparam int LAT_TEMP   = 4;
    localparam int LAT_HUM    = 10;
    localparam int LAT_PRESS  = 85;
    localparam int DIV_STAGES = 64;

    localparam t_w64 PRESS_TFINE_OFS = 64'd128000;
    localparam t_w32 HUM_TFINE_OFS   = 32'd76800;
    localparam t_w64 PRESS_ADC_FULL  = 64'd1048576;
    localparam t_w64 PRESS_SCALE     = 64'd3125;
    localparam t_w64 PRESS_BIAS      = 64'h0000_8000_0000_0000;
    localparam t_w32 HUM_MAX         = 32'd419430400;

endpackage

// ===== src/esc_if.sv =====
// ============================================================================
// esc_if
// Channel interfaces: raw burst input, compensated output, register writes.
// ============================================================================
interface esc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] press_msb;
    logic [7:0] press_lsb;
    logic [7:0] press_xlsb;
    logic [7:0] temp_msb;
    logic [7:0] temp_lsb;
    logic [7:0] temp_xlsb;
    logic [7:0] hum_msb;
    logic [7:0] hum_lsb;

    modport source (output valid, press_msb, press_lsb, press_xlsb, temp_msb, temp_lsb,
                    temp_xlsb, hum_msb, hum_lsb, input ready);
    modport sink   (input valid, press_msb, press_lsb, press_xlsb, temp_msb, temp_lsb,
                    temp_xlsb, hum_msb, hum_lsb, output ready);
endinterface

interface esc_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] temperature_centi;
    logic [31:0]        pressure_q24_8;
    logic [16:0]        humidity_q22_10;
    logic               status;

    modport source (output valid, temperature_centi, pressure_q24_8, humidity_q22_10,
                    status, input ready);
    modport sink   (input valid, temperature_centi, pressure_q24_8, humidity_q22_10,
                    status, output ready);
endinterface

interface esc_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [63:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== src/esc_mul64.sv =====
// ============================================================================
// esc_mul64
// Two-stage multiplier giving the low 64 bits of a 64 x 64 product.
// ============================================================================
module esc_mul64 (
    input  logic          i_clk,
    input  logic          i_en,
    input  esc_pkg::t_w64 i_a,
    input  esc_pkg::t_w64 i_b,
    output esc_pkg::t_w64 o_p
);
    import esc_pkg::*;

    t_w64 r_ll;
    t_w32 r_lh;
    t_w32 r_hl;
    t_w64 r_p;
    t_w64 n_ll;
    t_w32 n_lh;
    t_w32 n_hl;

    always_comb begin
        n_ll = i_a[31:0] * i_b[31:0];
        n_lh = i_a[31:0] * i_b[63:32];
        n_hl = i_a[63:32] * i_b[31:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ll <= n_ll;
            r_lh <= n_lh;
            r_hl <= n_hl;
            r_p  <= r_ll + {r_lh + r_hl, 32'd0};
        end
    end

    assign o_p = r_p;

endmodule

// ===== src/esc_div.sv =====
// ============================================================================
// esc_div
// Pipelined signed 64-bit divider, one quotient bit per stage, truncating.
// ============================================================================
module esc_div (
    input  logic          i_clk,
    input  logic          i_en,
    input  esc_pkg::t_w64 i_num,
    input  esc_pkg::t_w64 i_den,
    input  logic          i_tag,
    output esc_pkg::t_w64 o_quo,
    output logic          o_tag
);
    import esc_pkg::*;

    t_w64 r_rem [0:DIV_STAGES];
    t_w64 r_dq  [0:DIV_STAGES];
    t_w64 r_den [0:DIV_STAGES];
    logic r_neg [0:DIV_STAGES];
    logic r_tag [0:DIV_STAGES];
    t_w64 n_rem [0:DIV_STAGES-1];
    t_w64 n_dq  [0:DIV_STAGES-1];
    t_w64 r_quo;
    logic r_tag_o;
    logic [64:0] w_r2 [0:DIV_STAGES-1];
    logic        w_ge [0:DIV_STAGES-1];

    always_comb begin
        for (int k = 0; k < DIV_STAGES; k++) begin
            w_r2[k]  = {r_rem[k], r_dq[k][63]};
            w_ge[k]  = w_r2[k] >= {1'b0, r_den[k]};
            n_rem[k] = w_ge[k] ? 64'(w_r2[k] - {1'b0, r_den[k]}) : w_r2[k][63:0];
            n_dq[k]  = {r_dq[k][62:0], w_ge[k]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= '0;
            r_dq[0]  <= i_num[63] ? 64'(-i_num) : i_num;
            r_den[0] <= i_den[63] ? 64'(-i_den) : i_den;
            r_neg[0] <= i_num[63] ^ i_den[63];
            r_tag[0] <= i_tag;
            for (int k = 0; k < DIV_STAGES; k++) begin
                r_rem[k+1] <= n_rem[k];
                r_dq[k+1]  <= n_dq[k];
                r_den[k+1] <= r_den[k];
                r_neg[k+1] <= r_neg[k];
                r_tag[k+1] <= r_tag[k];
            end
            r_quo   <= r_neg[DIV_STAGES] ? 64'(-r_dq[DIV_STAGES]) : r_dq[DIV_STAGES];
            r_tag_o <= r_tag[DIV_STAGES];
        end
    end

    assign o_quo = r_quo;
    assign o_tag = r_tag_o;

endmodule

// ===== src/esc_temp.sv =====
// ============================================================================
// esc_temp
// Temperature stages: fine temperature value and saturated 0.01 degC result.
// ============================================================================
module esc_temp (
    input  logic               i_clk,
    input  logic               i_en,
    input  esc_pkg::t_adc20    i_adc_t,
    input  logic [47:0]        i_coeffs,
    output esc_pkg::t_w32      o_t_fine,
    output logic signed [15:0] o_temp
);
    import esc_pkg::*;

    t_w32 w_t1;
    t_w32 w_t2;
    t_w32 w_t3;
    t_w32 w_adc;
    t_w32 w_a;
    t_w32 w_d;
    t_w32 w_v1;
    t_w32 w_sc;
    logic signed [31:0] w_tv;
    t_w32 r_m1;
    t_w32 r_dd;
    t_w32 r_v1;
    t_w32 r_m3;
    t_w32 r_tf;
    logic signed [15:0] r_temp;
    logic signed [15:0] n_temp;

    always_comb begin
        w_t1  = {16'd0, i_coeffs[15:0]};
        w_t2  = {{16{i_coeffs[31]}}, i_coeffs[31:16]};
        w_t3  = {{16{i_coeffs[47]}}, i_coeffs[47:32]};
        w_adc = {12'd0, i_adc_t};
        w_a   = (w_adc >> 3) - (w_t1 << 1);
        w_d   = (w_adc >> 4) - w_t1;
        w_v1  = $unsigned($signed(r_dd) >>> 12);
        w_sc  = (r_tf << 2) + r_tf + 32'd128;
        w_tv  = $signed(w_sc) >>> 8;
        if (w_tv > 32'sd32767) begin
            n_temp = 16'sh7fff;
        end else if (w_tv < -32'sd32768) begin
            n_temp = 16'sh8000;
        end else begin
            n_temp = w_tv[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_m1   <= w_a * w_t2;
            r_dd   <= w_d * w_d;
            r_v1   <= $unsigned($signed(r_m1) >>> 11);
            r_m3   <= w_v1 * w_t3;
            r_tf   <= r_v1 + $unsigned($signed(r_m3) >>> 14);
            r_temp <= n_temp;
        end
    end

    assign o_t_fine = r_tf;
    assign o_temp   = r_temp;

endmodule

// ===== src/esc_hum.sv =====
// ============================================================================
// esc_hum
// Humidity stages: 32-bit compensation polynomial, clamped to 0..100 %RH.
// ============================================================================
module esc_hum (
    input  logic            i_clk,
    input  logic            i_en,
    input  esc_pkg::t_w32   i_t_fine,
    input  esc_pkg::t_adc16 i_adc_h,
    input  esc_pkg::t_w64   i_coeffs,
    output logic [16:0]     o_hum
);
    import esc_pkg::*;

    t_w32 w_h1;
    t_w32 w_h2;
    t_w32 w_h3;
    t_w32 w_h4;
    t_w32 w_h5;
    t_w32 w_h6;
    t_w32 w_x;
    t_w32 w_xs;
    t_w32 w_fin;
    t_w32 r_xh5;
    t_w32 r_x6;
    t_w32 r_x3;
    t_adc16 r_adc;
    t_w32 r_left;
    t_w32 r_prod;
    t_w32 r_ih2;
    t_w32 r_left2;
    t_w32 r_lr;
    t_w32 r_sq;
    t_w32 r_lr2;
    t_w32 r_q;
    t_w32 r_lr3;
    logic [16:0] r_hum;
    logic [16:0] n_hum;

    always_comb begin
        w_h1  = {24'd0, i_coeffs[7:0]};
        w_h2  = {{16{i_coeffs[23]}}, i_coeffs[23:8]};
        w_h3  = {24'd0, i_coeffs[31:24]};
        w_h4  = {{20{i_coeffs[43]}}, i_coeffs[43:32]};
        w_h5  = {{20{i_coeffs[55]}}, i_coeffs[55:44]};
        w_h6  = {{24{i_coeffs[63]}}, i_coeffs[63:56]};
        w_x   = i_t_fine - HUM_TFINE_OFS;
        w_xs  = $unsigned($signed(r_lr) >>> 15);
        w_fin = r_lr3 - $unsigned($signed(r_q) >>> 4);
        if (w_fin[31]) begin
            n_hum = '0;
        end else if (w_fin > HUM_MAX) begin
            n_hum = HUM_MAX[28:12];
        end else begin
            n_hum = w_fin[28:12];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_xh5   <= w_h5 * w_x;
            r_x6    <= w_x * w_h6;
            r_x3    <= w_x * w_h3;
            r_adc   <= i_adc_h;
            r_left  <= $unsigned($signed(({16'd0, r_adc} << 14) - (w_h4 << 20) - r_xh5
                                         + 32'd16384) >>> 15);
            r_prod  <= $unsigned($signed(r_x6) >>> 10)
                       * ($unsigned($signed(r_x3) >>> 11) + 32'd32768);
            r_ih2   <= ($unsigned($signed(r_prod) >>> 10) + 32'd2097152) * w_h2;
            r_left2 <= r_left;
            r_lr    <= r_left2 * $unsigned($signed(r_ih2 + 32'd8192) >>> 14);
            r_sq    <= w_xs * w_xs;
            r_lr2   <= r_lr;
            r_q     <= $unsigned($signed(r_sq) >>> 7) * w_h1;
            r_lr3   <= r_lr2;
            r_hum   <= n_hum;
        end
    end

    assign o_hum = r_hum;

endmodule

// ===== src/esc_press.sv =====
// ============================================================================
// esc_press
// Pressure stages: 64-bit polynomial, pipelined division and final trim.
// ============================================================================
module esc_press (
    input  logic            i_clk,
    input  logic            i_en,
    input  esc_pkg::t_w32   i_t_fine,
    input  esc_pkg::t_adc20 i_adc_p,
    input  esc_pkg::t_w64   i_coeffs_low,
    input  esc_pkg::t_w64   i_coeffs_high,
    input  logic [15:0]     i_coeff_nine,
    output logic [31:0]     o_press,
    output logic            o_status
);
    import esc_pkg::*;

    t_w64 w_p1;
    t_w64 w_p2;
    t_w64 w_p3;
    t_w64 w_p4;
    t_w64 w_p5;
    t_w64 w_p6;
    t_w64 w_p7;
    t_w64 w_p8;
    t_w64 w_p9;
    t_w64 w_praw;
    t_w64 w_ps;
    t_w64 w_sum;

    t_w64   r_w1;
    t_adc20 r_adc [0:5];
    t_w64   w_sq;
    t_w64   w_m5;
    t_w64   w_m2;
    t_w64   r_m5 [0:1];
    t_w64   r_m2 [0:1];
    t_w64   w_w2a;
    t_w64   w_s3;
    t_w64   r_w2;
    t_w64   r_v;
    t_w64   r_t;
    t_w64   r_n0;
    t_w64   w_mp1;
    t_w64   w_num;
    t_w64   r_den;
    t_w64   r_num;
    logic   r_zero;
    t_w64   w_quo;
    logic   w_qtag;
    t_w64   w_p8q;
    t_w64   w_pss;
    t_w64   r_q [0:3];
    logic   r_z [0:4];
    t_w64   w_m9;
    t_w64   r_x2 [0:1];
    t_w64   r_s;
    logic [31:0] r_press;
    logic   r_status;

    always_comb begin
        w_p1   = {48'd0, i_coeffs_low[15:0]};
        w_p2   = {{48{i_coeffs_low[31]}}, i_coeffs_low[31:16]};
        w_p3   = {{48{i_coeffs_low[47]}}, i_coeffs_low[47:32]};
        w_p4   = {{48{i_coeffs_low[63]}}, i_coeffs_low[63:48]};
        w_p5   = {{48{i_coeffs_high[15]}}, i_coeffs_high[15:0]};
        w_p6   = {{48{i_coeffs_high[31]}}, i_coeffs_high[31:16]};
        w_p7   = {{48{i_coeffs_high[47]}}, i_coeffs_high[47:32]};
        w_p8   = {{48{i_coeffs_high[63]}}, i_coeffs_high[63:48]};
        w_p9   = {{48{i_coeff_nine[15]}}, i_coeff_nine};
        w_praw = PRESS_ADC_FULL - {44'd0, r_adc[5]};
        w_ps   = $unsigned($signed(w_quo) >>> 13);
        w_sum  = $unsigned($signed(r_s) >>> 8) + (w_p7 << 4);
    end

    esc_mul64 u_sq  (.i_clk(i_clk), .i_en(i_en), .i_a(r_w1), .i_b(r_w1), .o_p(w_sq));
    esc_mul64 u_m5  (.i_clk(i_clk), .i_en(i_en), .i_a(r_w1), .i_b(w_p5), .o_p(w_m5));
    esc_mul64 u_m2  (.i_clk(i_clk), .i_en(i_en), .i_a(r_w1), .i_b(w_p2), .o_p(w_m2));
    esc_mul64 u_w2a (.i_clk(i_clk), .i_en(i_en), .i_a(w_sq), .i_b(w_p6), .o_p(w_w2a));
    esc_mul64 u_s3  (.i_clk(i_clk), .i_en(i_en), .i_a(w_sq), .i_b(w_p3), .o_p(w_s3));
    esc_mul64 u_mp1 (.i_clk(i_clk), .i_en(i_en), .i_a(r_t), .i_b(w_p1), .o_p(w_mp1));
    esc_mul64 u_num (.i_clk(i_clk), .i_en(i_en), .i_a(r_n0), .i_b(PRESS_SCALE),
                     .o_p(w_num));

    esc_div u_div (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_num (r_num),
        .i_den (r_den),
        .i_tag (r_zero),
        .o_quo (w_quo),
        .o_tag (w_qtag)
    );

    esc_mul64 u_p8q (.i_clk(i_clk), .i_en(i_en), .i_a(w_p8), .i_b(w_quo), .o_p(w_p8q));
    esc_mul64 u_pss (.i_clk(i_clk), .i_en(i_en), .i_a(w_ps), .i_b(w_ps), .o_p(w_pss));
    esc_mul64 u_m9  (.i_clk(i_clk), .i_en(i_en), .i_a(w_p9), .i_b(w_pss), .o_p(w_m9));

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_w1   <= {{32{i_t_fine[31]}}, i_t_fine} - PRESS_TFINE_OFS;
            r_adc[0] <= i_adc_p;
            for (int k = 1; k < 6; k++) begin
                r_adc[k] <= r_adc[k-1];
            end
            r_m5[0] <= w_m5;
            r_m5[1] <= r_m5[0];
            r_m2[0] <= w_m2;
            r_m2[1] <= r_m2[0];
            r_w2   <= w_w2a + (r_m5[1] << 17) + (w_p4 << 35);
            r_v    <= $unsigned($signed(w_s3) >>> 8) + (r_m2[1] << 12);
            r_t    <= PRESS_BIAS + r_v;
            r_n0   <= (w_praw << 31) - r_w2;
            r_den  <= $unsigned($signed(w_mp1) >>> 33);
            r_num  <= w_num;
            r_zero <= ($unsigned($signed(w_mp1) >>> 33) == '0);
            r_q[0] <= w_quo;
            r_z[0] <= w_qtag;
            for (int k = 1; k < 4; k++) begin
                r_q[k] <= r_q[k-1];
            end
            for (int k = 1; k < 5; k++) begin
                r_z[k] <= r_z[k-1];
            end
            r_x2[0] <= $unsigned($signed(w_p8q) >>> 19);
            r_x2[1] <= r_x2[0];
            r_s     <= r_q[3] + $unsigned($signed(w_m9) >>> 25) + r_x2[1];
            r_press <= r_z[4] ? '0 : w_sum[31:0];
            r_status <= r_z[4];
        end
    end

    assign o_press  = r_press;
    assign o_status = r_status;

endmodule

// ===== src/environmental_sensor_compensation_core.sv =====
// ============================================================================
// environmental_sensor_compensation_core
// Pressure, temperature and humidity compensation of one raw burst per item.
// ============================================================================
// Pipeline depth: set by the 64-stage pressure divider and the pipelined
// 64-bit multipliers around it.
// Throughput: one item per cycle; the pipeline holds while a result waits.
// Reset: synchronous, active low; clears valid bits and calibration registers.
module environmental_sensor_compensation_core (
    input  logic      i_clk,
    input  logic      i_rst_n,
    esc_in_if.sink    i_in,
    esc_out_if.source o_out,
    esc_cfg_if.sink   i_cfg
);
    import esc_pkg::*;

    logic [47:0] r_tc;
    t_w64        r_pl;
    t_w64        r_ph;
    logic [15:0] r_p9;
    t_w64        r_hc;

    logic [LAT_PRESS:0] r_v;
    logic w_en;
    logic w_in_rdy;

    t_adc20 r_adc_p;
    t_adc20 r_adc_t;
    t_adc16 r_adc_h;
    t_adc20 r_dp [0:LAT_TFINE-1];
    t_adc16 r_dh [0:LAT_TFINE-1];

    t_w32               w_t_fine;
    logic signed [15:0] w_temp;
    logic [16:0]        w_hum;
    logic [31:0]        w_press;
    logic               w_status;

    logic signed [15:0] r_td [0:LAT_PRESS-LAT_TEMP-1];
    logic [16:0]        r_hd [0:LAT_PRESS-LAT_HUM-1];

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tc <= '0;
            r_pl <= '0;
            r_ph <= '0;
            r_p9 <= '0;
            r_hc <= '0;
        end else if (i_cfg.valid) begin
            case (t_cfg_idx'(i_cfg.index))
                REG_TEMP_COEFFS:  r_tc <= i_cfg.data[47:0];
                REG_PRESS_LOW:    r_pl <= i_cfg.data;
                REG_PRESS_HIGH:   r_ph <= i_cfg.data;
                REG_PRESS_NINE:   r_p9 <= i_cfg.data[15:0];
                REG_HUMID_COEFFS: r_hc <= i_cfg.data;
                default: ;
            endcase
        end
    end

    assign w_en       = !r_v[LAT_PRESS] || o_out.ready;
    assign w_in_rdy   = w_en || !r_v[0];
    assign i_in.ready = w_in_rdy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_in_rdy) begin
                r_v[0] <= i_in.valid;
            end
            if (w_en) begin
                r_v[LAT_PRESS:1] <= r_v[LAT_PRESS-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_rdy && i_in.valid) begin
            r_adc_p <= {i_in.press_msb, i_in.press_lsb, i_in.press_xlsb[7:4]};
            r_adc_t <= {i_in.temp_msb, i_in.temp_lsb, i_in.temp_xlsb[7:4]};
            r_adc_h <= {i_in.hum_msb, i_in.hum_lsb};
        end
        if (w_en) begin
            r_dp[0] <= r_adc_p;
            r_dh[0] <= r_adc_h;
            for (int k = 1; k < LAT_TFINE; k++) begin
                r_dp[k] <= r_dp[k-1];
                r_dh[k] <= r_dh[k-1];
            end
            r_td[0] <= w_temp;
            for (int k = 1; k < LAT_PRESS - LAT_TEMP; k++) begin
                r_td[k] <= r_td[k-1];
            end
            r_hd[0] <= w_hum;
            for (int k = 1; k < LAT_PRESS - LAT_HUM; k++) begin
                r_hd[k] <= r_hd[k-1];
            end
        end
    end

    esc_temp u_temp (
        .i_clk    (i_clk),
        .i_en     (w_en),
        .i_adc_t  (r_adc_t),
        .i_coeffs (r_tc),
        .o_t_fine (w_t_fine),
        .o_temp   (w_temp)
    );

    esc_hum u_hum (
        .i_clk    (i_clk),
        .i_en     (w_en),
        .i_t_fine (w_t_fine),
        .i_adc_h  (r_dh[LAT_TFINE-1]),
        .i_coeffs (r_hc),
        .o_hum    (w_hum)
    );

    esc_press u_press (
        .i_clk         (i_clk),
        .i_en          (w_en),
        .i_t_fine      (w_t_fine),
        .i_adc_p       (r_dp[LAT_TFINE-1]),
        .i_coeffs_low  (r_pl),
        .i_coeffs_high (r_ph),
        .i_coeff_nine  (r_p9),
        .o_press       (w_press),
        .o_status      (w_status)
    );

    assign o_out.valid             = r_v[LAT_PRESS];
    assign o_out.temperature_centi = r_td[LAT_PRESS-LAT_TEMP-1];
    assign o_out.pressure_q24_8    = w_press;
    assign o_out.humidity_q22_10   = r_hd[LAT_PRESS-LAT_HUM-1];
    assign o_out.status            = w_status;

endmodule
